[rtl/emvt_pkg.sv]
// Shared widths, register indexes, defaults and command codes for the
// multi-turn encoder velocity tracker. No dependencies.
`timescale 1ns / 1ps
package emvt_pkg;

  localparam int ANGLE_BITS_DEF = 12;
  localparam int TIMER_BITS_DEF = 24;
  localparam int TURN_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam int ANGLE_OUT_W = 28;
  localparam int VEL_W       = 32;
  localparam int THRESH_W    = 12;
  localparam int RATE_W      = 27;
  localparam int INTERVAL_W  = 24;
  localparam int CFG_DATA_W  = 27;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_WRAP_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TICK_RATE      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_INTERVAL   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_INTERVAL   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FALLBACK       = 3'd4;

  localparam logic [THRESH_W-1:0]   WRAP_THRESHOLD_RST = 12'd3277;
  localparam logic [RATE_W-1:0]     TICK_RATE_RST      = 27'd9000000;
  localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST   = 24'd900;
  localparam logic [INTERVAL_W-1:0] MAX_INTERVAL_RST   = 24'd450000;
  localparam logic [INTERVAL_W-1:0] FALLBACK_RST       = 24'd9000;

  localparam logic OP_INIT   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] CMD_INIT = 2'd0;
  localparam logic [KIND_W-1:0] CMD_HOLD = 2'd1;
  localparam logic [KIND_W-1:0] CMD_RUN  = 2'd2;

  typedef struct packed {
    logic [THRESH_W-1:0]   wrap_threshold;
    logic [RATE_W-1:0]     tick_rate_hz;
    logic [INTERVAL_W-1:0] min_interval_ticks;
    logic [INTERVAL_W-1:0] max_interval_ticks;
    logic [INTERVAL_W-1:0] fallback_interval_ticks;
  } cfg_t;

endpackage

[rtl/emvt_if.sv]
// Valid/ready channel interfaces for sample items and result items.
// Depends on emvt_pkg.
`timescale 1ns / 1ps
interface emvt_in_if #(
  parameter int ANGLE_BITS = emvt_pkg::ANGLE_BITS_DEF,
  parameter int TIMER_BITS = emvt_pkg::TIMER_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [ANGLE_BITS-1:0] raw_angle;
  logic [TIMER_BITS-1:0] timer_stamp;

  modport source (output valid, output op, output raw_angle, output timer_stamp,
                  input ready);
  modport sink (input valid, input op, input raw_angle, input timer_stamp,
                output ready);
endinterface

interface emvt_out_if ();
  logic                                       valid;
  logic                                       ready;
  logic signed [emvt_pkg::ANGLE_OUT_W-1:0]    angle_counts;
  logic signed [emvt_pkg::VEL_W-1:0]          velocity_cps;
  logic                                       held;

  modport source (output valid, output angle_counts, output velocity_cps,
                  output held, input ready);
  modport sink (input valid, input angle_counts, input velocity_cps,
                input held, output ready);
endinterface

[rtl/emvt_front.sv]
// Front end: accepts items, measures the timer interval and classifies each
// item as init, hold or run. Depends on emvt_pkg and emvt_if.
`timescale 1ns / 1ps
module emvt_front #(
  parameter int ANGLE_BITS = emvt_pkg::ANGLE_BITS_DEF,
  parameter int TIMER_BITS = emvt_pkg::TIMER_BITS_DEF,
  parameter int TICK_W     = emvt_pkg::INTERVAL_W,
  parameter int CMD_W      = emvt_pkg::KIND_W + ANGLE_BITS + TICK_W
) (
  input  logic               clk,
  input  logic               rst,
  input  emvt_pkg::cfg_t     cfg,
  emvt_in_if.sink            samp,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output logic [CMD_W-1:0]   cmd
);

  logic [TIMER_BITS-1:0]      prev_stamp;
  logic [TIMER_BITS-1:0]      ticks_raw;
  logic [TICK_W-1:0]          ticks_ext;
  logic [TICK_W-1:0]          fallback;
  logic [TICK_W-1:0]          ticks;
  logic [emvt_pkg::KIND_W-1:0] kind;
  logic                       fire;

  assign samp.ready = cmd_ready && !rst;
  assign fire       = samp.valid && samp.ready;
  assign cmd_valid  = samp.valid && !rst;

  always_comb begin
    ticks_raw = prev_stamp + ~samp.timer_stamp +
                TIMER_BITS'(samp.timer_stamp < prev_stamp);
    ticks_ext = TICK_W'(ticks_raw);
    fallback  = (cfg.fallback_interval_ticks == '0) ? TICK_W'(1)
                                                     : TICK_W'(cfg.fallback_interval_ticks);
    ticks = ticks_ext;
    if (samp.op == emvt_pkg::OP_INIT) begin
      kind = emvt_pkg::CMD_INIT;
    end else if (ticks_ext == '0 || ticks_ext > TICK_W'(cfg.max_interval_ticks)) begin
      kind  = emvt_pkg::CMD_RUN;
      ticks = fallback;
    end else if (ticks_ext < TICK_W'(cfg.min_interval_ticks)) begin
      kind = emvt_pkg::CMD_HOLD;
    end else begin
      kind = emvt_pkg::CMD_RUN;
    end
  end

  assign cmd = {kind, samp.raw_angle, ticks};

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_stamp <= '0;
    end else if (fire && kind == emvt_pkg::CMD_RUN) begin
      prev_stamp <= samp.timer_stamp;
    end
  end

  a_stamp_update: assert property (@(posedge clk) disable iff (rst)
    (fire && kind == emvt_pkg::CMD_RUN) |=> prev_stamp == $past(samp.timer_stamp))
    else $error("prev_stamp not taken from a run item");

  a_stamp_keep: assert property (@(posedge clk) disable iff (rst)
    (!rst && !(fire && kind == emvt_pkg::CMD_RUN)) |=> $stable(prev_stamp))
    else $error("prev_stamp moved without a run item");

endmodule

[rtl/emvt_queue.sv]
// Short command queue between front and back end.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module emvt_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

[rtl/emvt_back.sv]
// Back end: unwraps the angle, scales the angle change by the tick rate and
// divides by the interval two bits a cycle. Depends on emvt_pkg and emvt_if.
`timescale 1ns / 1ps
module emvt_back #(
  parameter int ANGLE_BITS = emvt_pkg::ANGLE_BITS_DEF,
  parameter int TURN_BITS  = emvt_pkg::TURN_BITS_DEF,
  parameter int TICK_W     = emvt_pkg::INTERVAL_W,
  parameter int CMD_W      = emvt_pkg::KIND_W + ANGLE_BITS + TICK_W
) (
  input  logic             clk,
  input  logic             rst,
  input  emvt_pkg::cfg_t   cfg,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  logic [CMD_W-1:0] cmd,
  emvt_out_if.source       res
);

  localparam int AOW    = emvt_pkg::ANGLE_OUT_W;
  localparam int VW     = emvt_pkg::VEL_W;
  localparam int SUM_A  = TURN_BITS + ANGLE_BITS + 1;
  localparam int SUM_W  = (SUM_A > AOW + 1) ? SUM_A : AOW + 1;
  localparam int MAG_W  = AOW;
  localparam int PROD_W = MAG_W + emvt_pkg::RATE_W;
  localparam int DIV_STEPS = (PROD_W + 1) / 2;
  localparam int DIV_W  = 2 * DIV_STEPS;
  localparam int CNT_W  = $clog2(DIV_STEPS);
  localparam int REM_W  = TICK_W + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ANG   = 3'd1;
  localparam logic [2:0] S_DELTA = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic signed [SUM_W-1:0] AMAX = SUM_W'((64'd1 << (AOW - 1)) - 64'd1);
  localparam logic signed [SUM_W-1:0] AMIN = ~AMAX;
  localparam logic signed [TURN_BITS-1:0] TMAX = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] TMIN = {1'b1, {(TURN_BITS-1){1'b0}}};
  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  logic [2:0]                  state;
  logic [emvt_pkg::KIND_W-1:0] cmd_kind;
  logic [ANGLE_BITS-1:0]       cmd_raw;
  logic [TICK_W-1:0]           cmd_ticks;
  logic                        out_free;

  logic [ANGLE_BITS-1:0]       raw_r;
  logic [TICK_W-1:0]           divisor;
  logic [ANGLE_BITS-1:0]       prev_raw_angle;
  logic signed [TURN_BITS-1:0] turn_count;
  logic signed [AOW-1:0]       tracked_angle;
  logic signed [AOW-1:0]       velocity_angle;
  logic [VW-1:0]               last_velocity;
  logic [MAG_W-1:0]            delta_mag;
  logic                        delta_neg;
  logic [REM_W-1:0]            rem;
  logic [DIV_W-1:0]            dq;
  logic [CNT_W-1:0]            div_cnt;

  logic signed [ANGLE_BITS:0]  d;
  logic [ANGLE_BITS:0]         d_mag;
  logic                        turn_cross;
  logic signed [TURN_BITS-1:0] turn_next;
  logic signed [SUM_W-1:0]     sum;
  logic signed [AOW-1:0]       ang_next;
  logic signed [AOW:0]         delta;
  logic [REM_W-1:0]            rem_next;
  logic [DIV_W-1:0]            dq_next;
  logic [VW-1:0]               vel;

  assign cmd_kind  = cmd[CMD_W-1 -: emvt_pkg::KIND_W];
  assign cmd_raw   = cmd[TICK_W +: ANGLE_BITS];
  assign cmd_ticks = cmd[TICK_W-1:0];
  assign out_free  = !res.valid || res.ready;
  assign cmd_ready = (state == S_IDLE) && !rst &&
                     (cmd_kind == emvt_pkg::CMD_RUN || out_free);

  always_comb begin
    d     = $signed({1'b0, raw_r}) - $signed({1'b0, prev_raw_angle});
    d_mag = d[ANGLE_BITS] ? $unsigned(-d) : $unsigned(d);
    turn_cross = 32'(d_mag) >= 32'(cfg.wrap_threshold);
    turn_next = turn_count;
    if (turn_cross) begin
      if (d > 0) begin
        if (turn_count != TMIN) turn_next = turn_count - 1'b1;
      end else begin
        if (turn_count != TMAX) turn_next = turn_count + 1'b1;
      end
    end
    sum = (SUM_W'(turn_next) <<< ANGLE_BITS) + $signed(SUM_W'(raw_r));
    if (sum > AMAX) begin
      ang_next = AOW'(AMAX);
    end else if (sum < AMIN) begin
      ang_next = AOW'(AMIN);
    end else begin
      ang_next = AOW'(sum);
    end
  end

  assign delta = {tracked_angle[AOW-1], tracked_angle} -
                 {velocity_angle[AOW-1], velocity_angle};

  always_comb begin
    rem_next = rem;
    dq_next  = dq;
    for (int i = 0; i < 2; i++) begin
      rem_next = {rem_next[REM_W-2:0], dq_next[DIV_W-1]};
      dq_next  = {dq_next[DIV_W-2:0], 1'b0};
      if (rem_next >= {1'b0, divisor}) begin
        rem_next   = rem_next - {1'b0, divisor};
        dq_next[0] = 1'b1;
      end
    end
  end

  always_comb begin
    if (!delta_neg) begin
      vel = (dq > DIV_W'(VMAX)) ? VMAX : VW'(dq);
    end else if (dq > DIV_W'(64'd1 << (VW - 1))) begin
      vel = VMIN;
    end else begin
      vel = VW'(-dq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      res.valid      <= 1'b0;
      div_cnt        <= '0;
      prev_raw_angle <= '0;
      turn_count     <= '0;
      tracked_angle  <= '0;
      velocity_angle <= '0;
      last_velocity  <= '0;
    end else begin
      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            case (cmd_kind)
              emvt_pkg::CMD_INIT: begin
                prev_raw_angle   <= cmd_raw;
                turn_count       <= '0;
                tracked_angle    <= AOW'(cmd_raw);
                velocity_angle   <= AOW'(cmd_raw);
                last_velocity    <= '0;
                res.valid        <= 1'b1;
                res.angle_counts <= AOW'(cmd_raw);
                res.velocity_cps <= '0;
                res.held         <= 1'b0;
              end
              emvt_pkg::CMD_HOLD: begin
                res.valid        <= 1'b1;
                res.angle_counts <= tracked_angle;
                res.velocity_cps <= last_velocity;
                res.held         <= 1'b1;
              end
              default: begin
                raw_r   <= cmd_raw;
                divisor <= cmd_ticks;
                state   <= S_ANG;
              end
            endcase
          end
        end
        S_ANG: begin
          turn_count     <= turn_next;
          prev_raw_angle <= raw_r;
          tracked_angle  <= ang_next;
          state          <= S_DELTA;
        end
        S_DELTA: begin
          delta_neg      <= delta[AOW];
          delta_mag      <= delta[AOW] ? MAG_W'(-delta) : MAG_W'(delta);
          velocity_angle <= tracked_angle;
          state          <= S_MUL;
        end
        S_MUL: begin
          dq      <= DIV_W'(delta_mag * cfg.tick_rate_hz);
          rem     <= '0;
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          rem <= rem_next;
          dq  <= dq_next;
          if (div_cnt == CNT_W'(DIV_STEPS - 1)) begin
            div_cnt <= '0;
            state   <= S_DONE;
          end else begin
            div_cnt <= div_cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            last_velocity    <= vel;
            res.valid        <= 1'b1;
            res.angle_counts <= tracked_angle;
            res.velocity_cps <= vel;
            res.held         <= 1'b0;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < {1'b0, divisor}))
    else $error("divider remainder not below divisor");

  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_DIV) |-> (div_cnt == '0))
    else $error("divider count active outside division");

endmodule

[rtl/encoder_multiturn_velocity_tracker.sv]
// Top level of the multi-turn encoder velocity tracker: configuration
// registers, front end, command queue and back end. Depends on emvt_pkg,
// emvt_if, emvt_front, emvt_queue and emvt_back.
`timescale 1ns / 1ps
// A sample item is taken and queued; the back end then works through it
// (unwrap, delta, one multiply, a two-bit-a-cycle divider, result) and takes
// no new item until that result is registered. Init and held items skip the
// divider and are answered from the idle state. The divider sets the rate. The
// output is registered, so a result may wait on the sink while the queue keeps
// taking items. Write configuration only while no item is in flight.
module encoder_multiturn_velocity_tracker #(
  parameter int ANGLE_BITS  = emvt_pkg::ANGLE_BITS_DEF,
  parameter int TIMER_BITS  = emvt_pkg::TIMER_BITS_DEF,
  parameter int TURN_BITS   = emvt_pkg::TURN_BITS_DEF,
  parameter int QUEUE_DEPTH = emvt_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [emvt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [emvt_pkg::CFG_DATA_W-1:0]    cfg_data,
  emvt_in_if.sink                            samp,
  emvt_out_if.source                         res
);

  localparam int TICK_W = (TIMER_BITS > emvt_pkg::INTERVAL_W) ? TIMER_BITS
                                                              : emvt_pkg::INTERVAL_W;
  localparam int CMD_W  = emvt_pkg::KIND_W + ANGLE_BITS + TICK_W;

  emvt_pkg::cfg_t   cfg;
  logic             push_valid;
  logic             push_ready;
  logic [CMD_W-1:0] push_data;
  logic             pop_valid;
  logic             pop_ready;
  logic [CMD_W-1:0] pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wrap_threshold          <= emvt_pkg::WRAP_THRESHOLD_RST;
      cfg.tick_rate_hz            <= emvt_pkg::TICK_RATE_RST;
      cfg.min_interval_ticks      <= emvt_pkg::MIN_INTERVAL_RST;
      cfg.max_interval_ticks      <= emvt_pkg::MAX_INTERVAL_RST;
      cfg.fallback_interval_ticks <= emvt_pkg::FALLBACK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        emvt_pkg::REG_WRAP_THRESHOLD:
          cfg.wrap_threshold <= cfg_data[emvt_pkg::THRESH_W-1:0];
        emvt_pkg::REG_TICK_RATE:
          cfg.tick_rate_hz <= cfg_data[emvt_pkg::RATE_W-1:0];
        emvt_pkg::REG_MIN_INTERVAL:
          cfg.min_interval_ticks <= cfg_data[emvt_pkg::INTERVAL_W-1:0];
        emvt_pkg::REG_MAX_INTERVAL:
          cfg.max_interval_ticks <= cfg_data[emvt_pkg::INTERVAL_W-1:0];
        emvt_pkg::REG_FALLBACK:
          cfg.fallback_interval_ticks <= cfg_data[emvt_pkg::INTERVAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  emvt_front #(
    .ANGLE_BITS (ANGLE_BITS),
    .TIMER_BITS (TIMER_BITS),
    .TICK_W     (TICK_W),
    .CMD_W      (CMD_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .samp      (samp),
    .cmd_valid (push_valid),
    .cmd_ready (push_ready),
    .cmd       (push_data)
  );

  emvt_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  emvt_back #(
    .ANGLE_BITS (ANGLE_BITS),
    .TURN_BITS  (TURN_BITS),
    .TICK_W     (TICK_W),
    .CMD_W      (CMD_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_data),
    .res       (res)
  );

endmodule

[verif/encoder_multiturn_velocity_tracker_tb.sv]
// Self-checking testbench for encoder_multiturn_velocity_tracker: directed and
// random encoder items are checked against an in-bench model of turn unwrapping
// and velocity. Depends on emvt_pkg, emvt_if and the tracker RTL.
`timescale 1ns / 1ps
module encoder_multiturn_velocity_tracker_tb;

  localparam int     ANGLE_W    = emvt_pkg::ANGLE_BITS_DEF;
  localparam int     TIMER_W    = emvt_pkg::TIMER_BITS_DEF;
  localparam int     AOW        = emvt_pkg::ANGLE_OUT_W;
  localparam int     VW         = emvt_pkg::VEL_W;
  localparam int     CFG_W      = emvt_pkg::CFG_DATA_W;
  localparam longint TIMER_MASK = (longint'(1) << TIMER_W) - 1;
  localparam longint TURN_MAX   = (longint'(1) << (emvt_pkg::TURN_BITS_DEF - 1)) - 1;
  localparam longint ANGLE_MAX  = (longint'(1) << (AOW - 1)) - 1;
  localparam longint VEL_MAX    = (longint'(1) << (VW - 1)) - 1;
  localparam int     ANGLE_TOP  = (1 << ANGLE_W) - 1;
  localparam int     STAMP_TOP  = (1 << TIMER_W) - 1;
  localparam int     THRESH_TOP = (1 << emvt_pkg::THRESH_W) - 1;
  localparam int     RATE_TOP   = (1 << emvt_pkg::RATE_W) - 1;
  localparam int     HOLDOFF_CYCLES = 400;
  localparam int     DRAIN_CYCLES   = 40;

  typedef struct {
    logic signed [AOW-1:0] angle_counts;
    logic signed [VW-1:0]  velocity_cps;
    logic                  held;
  } reading_t;

  logic                             clk;
  logic                             rst;
  logic                             cfg_we;
  logic [emvt_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0]                 cfg_data;

  emvt_in_if  samp_ch ();
  emvt_out_if res_ch ();

  encoder_multiturn_velocity_tracker DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .samp(samp_ch),
    .res(res_ch)
  );

  // tracker model state and register copies
  logic [emvt_pkg::THRESH_W-1:0]   m_thresh;
  logic [emvt_pkg::RATE_W-1:0]     m_rate;
  logic [emvt_pkg::INTERVAL_W-1:0] m_min_ivl;
  logic [emvt_pkg::INTERVAL_W-1:0] m_max_ivl;
  logic [emvt_pkg::INTERVAL_W-1:0] m_fallback;
  logic [ANGLE_W-1:0]              m_prev_raw;
  logic [TIMER_W-1:0]              m_prev_stamp;
  longint                          m_turns;
  longint                          m_tracked;
  longint                          m_vel_angle;
  longint                          m_last_vel;

  reading_t pending_readings[$];
  int       mismatch_count;
  bit       src_idle_on;
  bit       sink_idle_on;
  int       holdoff_asks;
  int       trk_angle;
  int       trk_stamp;
  int       trk_speed;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("encoder_multiturn_velocity_tracker verification failed");
    $finish;
  end

  function automatic longint limit_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic reading_t track_encoder(logic op, logic [ANGLE_W-1:0] raw,
                                             logic [TIMER_W-1:0] stamp);
    reading_t r;
    longint   ticks;
    longint   jump;
    longint   span;
    longint   ang;
    longint   vel;
    r.held = 1'b0;
    if (op == emvt_pkg::OP_INIT) begin
      m_prev_raw     = raw;
      m_turns        = 0;
      m_tracked      = longint'(raw);
      m_vel_angle    = m_tracked;
      m_last_vel     = 0;
      r.angle_counts = AOW'(raw);
      r.velocity_cps = '0;
      return r;
    end
    if (stamp < m_prev_stamp)
      ticks = longint'(m_prev_stamp) - longint'(stamp);
    else
      ticks = (TIMER_MASK - longint'(stamp) + longint'(m_prev_stamp)) & TIMER_MASK;
    if (ticks == 0 || ticks > longint'(m_max_ivl)) begin
      ticks = (m_fallback == '0) ? longint'(1) : longint'(m_fallback);
    end else if (ticks < longint'(m_min_ivl)) begin
      r.angle_counts = m_tracked[AOW-1:0];
      r.velocity_cps = m_last_vel[VW-1:0];
      r.held         = 1'b1;
      return r;
    end
    jump = longint'(raw) - longint'(m_prev_raw);
    span = (jump < 0) ? -jump : jump;
    if (span >= longint'(m_thresh))
      m_turns = limit_to(m_turns + longint'((jump > 0) ? -1 : 1), -TURN_MAX - 1,
                         TURN_MAX);
    m_prev_raw = raw;
    ang = limit_to(m_turns * (longint'(1) << ANGLE_W) + longint'(raw),
                   -ANGLE_MAX - 1, ANGLE_MAX);
    m_tracked = ang;
    vel = ((ang - m_vel_angle) * longint'(m_rate)) / ticks;
    vel = limit_to(vel, -VEL_MAX - 1, VEL_MAX);
    m_last_vel     = vel;
    m_prev_stamp   = stamp;
    m_vel_angle    = ang;
    r.angle_counts = ang[AOW-1:0];
    r.velocity_cps = vel[VW-1:0];
    return r;
  endfunction

  // result checker and receiver-side flow control
  initial begin : reading_monitor
    int       hold_left;
    int       holdoff_seen;
    reading_t want;
    hold_left    = 0;
    holdoff_seen = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        if (pending_readings.size() == 0) begin
          $error("unexpected item: angle_counts %0d velocity_cps %0d held %0b",
                 res_ch.angle_counts, res_ch.velocity_cps, res_ch.held);
          mismatch_count++;
        end else begin
          want = pending_readings.pop_front();
          if (res_ch.angle_counts !== want.angle_counts) begin
            $error("angle_counts: expected %0d, got %0d", want.angle_counts,
                   res_ch.angle_counts);
            mismatch_count++;
          end
          if (res_ch.velocity_cps !== want.velocity_cps) begin
            $error("velocity_cps: expected %0d, got %0d", want.velocity_cps,
                   res_ch.velocity_cps);
            mismatch_count++;
          end
          if (res_ch.held !== want.held) begin
            $error("held: expected %0b, got %0b", want.held, res_ch.held);
            mismatch_count++;
          end
        end
      end
      if (holdoff_seen != holdoff_asks) begin
        hold_left    = HOLDOFF_CYCLES;
        holdoff_seen = holdoff_asks;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (sink_idle_on) begin
        res_ch.ready <= ($urandom_range(99) >= 34);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic op, logic [ANGLE_W-1:0] raw,
                           logic [TIMER_W-1:0] stamp);
    int gap;
    gap = 0;
    if (src_idle_on)
      while ($urandom_range(99) < 34) gap++;
    if (gap > 0) begin
      samp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samp_ch.valid       <= 1'b1;
    samp_ch.op          <= op;
    samp_ch.raw_angle   <= raw;
    samp_ch.timer_stamp <= stamp;
    @(posedge clk);
    while (samp_ch.ready !== 1'b1) @(posedge clk);
    pending_readings.push_back(track_encoder(op, raw, stamp));
  endtask

  task automatic wait_drain();
    samp_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [emvt_pkg::CFG_INDEX_W-1:0] index,
                           logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      emvt_pkg::REG_WRAP_THRESHOLD: m_thresh   = data[emvt_pkg::THRESH_W-1:0];
      emvt_pkg::REG_TICK_RATE:      m_rate     = data[emvt_pkg::RATE_W-1:0];
      emvt_pkg::REG_MIN_INTERVAL:   m_min_ivl  = data[emvt_pkg::INTERVAL_W-1:0];
      emvt_pkg::REG_MAX_INTERVAL:   m_max_ivl  = data[emvt_pkg::INTERVAL_W-1:0];
      emvt_pkg::REG_FALLBACK:       m_fallback = data[emvt_pkg::INTERVAL_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(int thresh, int rate, int min_ivl, int max_ivl, int fallback);
    cfg_write(emvt_pkg::REG_WRAP_THRESHOLD, CFG_W'(thresh));
    cfg_write(emvt_pkg::REG_TICK_RATE, CFG_W'(rate));
    cfg_write(emvt_pkg::REG_MIN_INTERVAL, CFG_W'(min_ivl));
    cfg_write(emvt_pkg::REG_MAX_INTERVAL, CFG_W'(max_ivl));
    cfg_write(emvt_pkg::REG_FALLBACK, CFG_W'(fallback));
  endtask

  // advance a plausibly moving encoder by one sample
  task automatic send_tracking_sample();
    int step;
    case ($urandom_range(9))
      0:       step = $urandom_range(m_min_ivl);
      1:       step = $urandom_range(STAMP_TOP, m_max_ivl);
      default: step = $urandom_range(m_max_ivl, m_min_ivl);
    endcase
    trk_stamp = (trk_stamp - step) & STAMP_TOP;
    trk_angle = (trk_angle + trk_speed) & ANGLE_TOP;
    send_item(emvt_pkg::OP_SAMPLE, ANGLE_W'(trk_angle), TIMER_W'(trk_stamp));
  endtask

  task automatic test_directed_tracking();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    send_item(emvt_pkg::OP_INIT, 12'd4095, 24'h123456);
    send_item(emvt_pkg::OP_SAMPLE, 12'd0, 24'hFFFFFF);
    send_item(emvt_pkg::OP_SAMPLE, 12'd4095, 24'hFFFFFF);
    send_item(emvt_pkg::OP_SAMPLE, 12'd100, m_prev_stamp - 24'd500);
    send_item(emvt_pkg::OP_SAMPLE, 12'd200, m_prev_stamp - 24'd899);
    send_item(emvt_pkg::OP_SAMPLE, 12'd300, m_prev_stamp - 24'd900);
    send_item(emvt_pkg::OP_SAMPLE, 12'd4000, m_prev_stamp - 24'd450000);
    send_item(emvt_pkg::OP_SAMPLE, 12'd10, m_prev_stamp - 24'd450001);
    send_item(emvt_pkg::OP_SAMPLE, 12'd10, m_prev_stamp + 24'd10);
    send_item(emvt_pkg::OP_INIT, 12'd0, 24'd0);
    send_item(emvt_pkg::OP_SAMPLE, 12'd3277, m_prev_stamp - 24'd9000);
    send_item(emvt_pkg::OP_SAMPLE, 12'd1, m_prev_stamp - 24'd9000);
    wait_drain();
  endtask

  task automatic test_register_extremes();
    // zero threshold, zero rate, zero fallback
    set_config(0, 0, 0, 0, 0);
    send_item(emvt_pkg::OP_INIT, 12'd2048, TIMER_W'($urandom_range(STAMP_TOP)));
    send_item(emvt_pkg::OP_SAMPLE, 12'd2048, TIMER_W'($urandom_range(STAMP_TOP)));
    send_item(emvt_pkg::OP_SAMPLE, 12'd2048, TIMER_W'($urandom_range(STAMP_TOP)));
    wait_drain();
    // one-tick intervals at the top rate drive velocity into saturation
    set_config(THRESH_TOP, RATE_TOP, 0, STAMP_TOP, 1);
    send_item(emvt_pkg::OP_INIT, 12'd0, TIMER_W'($urandom_range(STAMP_TOP)));
    send_item(emvt_pkg::OP_SAMPLE, 12'd4094, m_prev_stamp - 24'd1);
    send_item(emvt_pkg::OP_SAMPLE, 12'd0, m_prev_stamp - 24'd1);
    send_item(emvt_pkg::OP_SAMPLE, 12'd4095, m_prev_stamp - 24'd1);
    send_item(emvt_pkg::OP_SAMPLE, 12'd0, m_prev_stamp - 24'd1);
    send_item(emvt_pkg::OP_SAMPLE, 12'd4095, m_prev_stamp);
    wait_drain();
  endtask

  task automatic test_output_backpressure();
    set_config(int'(emvt_pkg::WRAP_THRESHOLD_RST), int'(emvt_pkg::TICK_RATE_RST),
               int'(emvt_pkg::MIN_INTERVAL_RST), int'(emvt_pkg::MAX_INTERVAL_RST),
               int'(emvt_pkg::FALLBACK_RST));
    src_idle_on = 1'b0;
    trk_angle   = $urandom_range(ANGLE_TOP);
    trk_stamp   = $urandom_range(STAMP_TOP);
    trk_speed   = $urandom_range(600) - 300;
    send_item(emvt_pkg::OP_INIT, ANGLE_W'(trk_angle), TIMER_W'(trk_stamp));
    holdoff_asks++;
    repeat (12) send_tracking_sample();
    wait_drain();
    src_idle_on = 1'b1;
  endtask

  task automatic random_run(int count);
    int pick;
    trk_angle = $urandom_range(ANGLE_TOP);
    trk_stamp = $urandom_range(STAMP_TOP);
    trk_speed = $urandom_range(1600) - 800;
    send_item(emvt_pkg::OP_INIT, ANGLE_W'(trk_angle), TIMER_W'(trk_stamp));
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        trk_angle = $urandom_range(ANGLE_TOP);
        send_item(emvt_pkg::OP_INIT, ANGLE_W'(trk_angle),
                  TIMER_W'($urandom_range(STAMP_TOP)));
      end else if (pick < 15) begin
        send_item(emvt_pkg::OP_SAMPLE, ANGLE_W'($urandom_range(ANGLE_TOP)),
                  TIMER_W'($urandom_range(STAMP_TOP)));
      end else begin
        if ($urandom_range(19) == 0)
          trk_speed = $urandom_range(2 * ANGLE_TOP) - ANGLE_TOP;
        send_tracking_sample();
      end
    end
    wait_drain();
  endtask

  task automatic test_random_tracking();
    int min_ivl;
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    random_run(150);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    set_config(1, RATE_TOP, 0, STAMP_TOP, 1);
    random_run(170);
    set_config(THRESH_TOP, 1, STAMP_TOP, 0, STAMP_TOP);
    random_run(120);
    repeat (2) begin
      min_ivl = $urandom_range(20000);
      set_config($urandom_range(THRESH_TOP, 1), $urandom_range(RATE_TOP, 1), min_ivl,
                 min_ivl + $urandom_range(500000), $urandom_range(STAMP_TOP, 1));
      random_run(200);
    end
  endtask

  initial begin : stimulus
    mismatch_count      = 0;
    holdoff_asks        = 0;
    src_idle_on         = 1'b0;
    sink_idle_on        = 1'b0;
    m_thresh            = emvt_pkg::WRAP_THRESHOLD_RST;
    m_rate              = emvt_pkg::TICK_RATE_RST;
    m_min_ivl           = emvt_pkg::MIN_INTERVAL_RST;
    m_max_ivl           = emvt_pkg::MAX_INTERVAL_RST;
    m_fallback          = emvt_pkg::FALLBACK_RST;
    m_prev_raw          = '0;
    m_prev_stamp        = '0;
    m_turns             = 0;
    m_tracked           = 0;
    m_vel_angle         = 0;
    m_last_vel          = 0;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    samp_ch.valid       <= 1'b0;
    samp_ch.op          <= emvt_pkg::OP_INIT;
    samp_ch.raw_angle   <= '0;
    samp_ch.timer_stamp <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_tracking();
    test_register_extremes();
    test_output_backpressure();
    test_random_tracking();
    wait_drain();
    if (mismatch_count == 0) begin
      $display("encoder_multiturn_velocity_tracker verification clean");
    end else begin
      $display("encoder_multiturn_velocity_tracker verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/emvt_pkg.sv
rtl/emvt_if.sv
rtl/emvt_front.sv
rtl/emvt_queue.sv
rtl/emvt_back.sv
rtl/encoder_multiturn_velocity_tracker.sv
verif/encoder_multiturn_velocity_tracker_tb.sv
